### design/vep_pkg.sv
// ----------------------------------------------------------------------------
// vep_pkg: shared types and constants of the terminal escape and UTF-8 parser
// Byte codes, event kinds, state encodings and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vep_pkg;

    localparam int DEFAULT_MAX_PARAMS  = 32;
    localparam int DEFAULT_PARAM_LIMIT = 65535;

    localparam int EV_SLOTS = 3;
    localparam int SLOT_W   = 2;

    localparam logic [7:0] B_BEL    = 8'h07;
    localparam logic [7:0] B_ESC    = 8'h1B;
    localparam logic [7:0] B_SP     = 8'h20;
    localparam logic [7:0] B_INT_HI = 8'h2F;
    localparam logic [7:0] B_DIG0   = 8'h30;
    localparam logic [7:0] B_DIG9   = 8'h39;
    localparam logic [7:0] B_SEMI   = 8'h3B;
    localparam logic [7:0] B_FIN_LO = 8'h40;
    localparam logic [7:0] B_CSI    = 8'h5B;
    localparam logic [7:0] B_BSL    = 8'h5C;
    localparam logic [7:0] B_OSC    = 8'h5D;
    localparam logic [7:0] B_FIN_HI = 8'h7E;
    localparam logic [7:0] B_DEL    = 8'h7F;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    typedef enum logic [2:0] {
        K_PRINT     = 3'd0,
        K_EXECUTE   = 3'd1,
        K_ESC_FINAL = 3'd2,
        K_CSI_PARAM = 3'd3,
        K_OSC_BYTE  = 3'd4,
        K_OSC_END   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        P_GROUND,
        P_ESC,
        P_CSI,
        P_CSI_IGN,
        P_OSC,
        P_OSC_ESC
    } t_parse_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_EVENTS,
        C_READ,
        C_PARAMS
    } t_ctrl_state;

    typedef struct packed {
        t_kind       kind;
        logic [20:0] value;
        logic [7:0]  csi_final;
    } t_slot;

    typedef struct packed {
        logic              take;
        logic              load_evt;
        logic              load_par;
        logic              rd_en;
        logic              last;
        logic [SLOT_W-1:0] slot_sel;
    } t_cmd;

    typedef struct packed {
        logic              pre_disp;
        logic [SLOT_W-1:0] pre_n;
        logic [SLOT_W-1:0] ev_n;
        logic              out_free;
    } t_status;

endpackage

### design/vep_if.sv
// ----------------------------------------------------------------------------
// vep_if: stream interfaces of the parser
// The byte channel into the block and the event channel out of it, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface vep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface vep_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [20:0] event_value;
    logic [7:0]  csi_final;
    logic [4:0]  param_index;
    logic [5:0]  param_count;
    logic        last;

    modport source (
        output valid, output event_kind, output event_value, output csi_final,
        output param_index, output param_count, output last, input ready
    );
    modport sink (
        input valid, input event_kind, input event_value, input csi_final,
        input param_index, input param_count, input last, output ready
    );
endinterface

### design/vep_ctrl.sv
// ----------------------------------------------------------------------------
// vep_ctrl: event sequencing controller
// Accepts bytes and steps the datapath through the events that each byte
// causes, including the parameter memory reads of a CSI dispatch.
// ----------------------------------------------------------------------------
module vep_ctrl
    import vep_pkg::*;
#(
    parameter int MAX_PARAMS = DEFAULT_MAX_PARAMS,
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1,
    localparam int CW = $clog2(MAX_PARAMS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_status       i_status,
    input  logic [CW-1:0] i_disp_cnt,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_rd_addr,
    output logic [IW-1:0] o_par_idx
);

    t_ctrl_state       r_state, n_state;
    logic [SLOT_W-1:0] r_sidx, n_sidx;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic              slot_last;
    logic              par_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_sidx  <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            r_sidx  <= n_sidx;
            r_pidx  <= n_pidx;
        end
    end

    assign slot_last = (r_sidx + SLOT_W'(1)) == i_status.ev_n;
    assign par_last  = (CW'(r_pidx) + CW'(1)) == i_disp_cnt;
    assign o_par_idx = r_pidx;

    always_comb begin
        n_state    = r_state;
        n_sidx     = r_sidx;
        n_pidx     = r_pidx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_rd_addr  = r_pidx;
        case (r_state)
            C_IDLE: begin
                o_in_ready = 1'b1;
            end
            C_EVENTS: begin
                if (i_status.out_free) begin
                    o_cmd.load_evt = 1'b1;
                    o_cmd.slot_sel = r_sidx;
                    o_cmd.last     = slot_last;
                    if (slot_last) begin
                        o_in_ready = 1'b1;
                        n_state    = C_IDLE;
                    end else begin
                        n_sidx = r_sidx + SLOT_W'(1);
                    end
                end
            end
            C_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = C_PARAMS;
            end
            C_PARAMS: begin
                if (i_status.out_free) begin
                    o_cmd.load_par = 1'b1;
                    o_cmd.last     = par_last;
                    if (par_last) begin
                        n_state = C_IDLE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = r_pidx + IW'(1);
                        n_pidx      = r_pidx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
        if (o_in_ready && i_in_valid) begin
            o_cmd.take = 1'b1;
            n_sidx     = '0;
            n_pidx     = '0;
            if (i_status.pre_disp) begin
                n_state = C_READ;
            end else if (i_status.pre_n != '0) begin
                n_state = C_EVENTS;
            end else begin
                n_state = C_IDLE;
            end
        end
    end

endmodule

### design/vep_datapath.sv
// ----------------------------------------------------------------------------
// vep_datapath: parser state, UTF-8 decoder, parameter memory and output
// Decodes each byte into up to three events or a CSI dispatch, keeps the
// CSI parameters in a memory and drives the event output register.
// ----------------------------------------------------------------------------
module vep_datapath
    import vep_pkg::*;
#(
    parameter int MAX_PARAMS  = DEFAULT_MAX_PARAMS,
    parameter int PARAM_LIMIT = DEFAULT_PARAM_LIMIT,
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1,
    localparam int CW = $clog2(MAX_PARAMS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_data_byte,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_par_idx,
    output t_status       o_status,
    output logic [CW-1:0] o_disp_cnt,
    vep_event_if.source   o_event
);

    typedef struct packed {
        logic              esc;
        logic [SLOT_W-1:0] n;
        t_slot             s0;
        t_slot             s1;
        logic [1:0]        rem;
        logic [20:0]       acc;
    } t_ground;

    function automatic t_slot mk_slot(input t_kind kind, input logic [20:0] value,
                                      input logic [7:0] fin);
        t_slot s;
        s.kind      = kind;
        s.value     = value;
        s.csi_final = fin;
        return s;
    endfunction

    function automatic t_ground ground_eval(input logic [7:0] b, input logic [1:0] rem,
                                            input logic [20:0] acc);
        t_ground     g;
        logic        have;
        t_slot       x;
        logic [1:0]  r2;
        g     = '0;
        g.rem = rem;
        g.acc = acc;
        have  = 1'b0;
        x     = mk_slot(K_PRINT, CP_REPLACEMENT, 8'h00);
        r2    = rem - 2'd1;
        if (b == B_ESC) begin
            g.esc = 1'b1;
        end else if (b < B_SP || b == B_DEL) begin
            g.n  = SLOT_W'(1);
            g.s0 = mk_slot(K_EXECUTE, {13'b0, b}, 8'h00);
        end else if (rem != 2'd0 && b[7:6] == 2'b10) begin
            g.acc = {acc[14:0], b[5:0]};
            g.rem = r2;
            if (r2 == 2'd0) begin
                g.n  = SLOT_W'(1);
                g.s0 = mk_slot(K_PRINT, {acc[14:0], b[5:0]}, 8'h00);
            end
        end else begin
            if (rem != 2'd0) begin
                g.rem = 2'd0;
                g.n   = SLOT_W'(1);
                g.s0  = mk_slot(K_PRINT, CP_REPLACEMENT, 8'h00);
            end
            if (b[7] == 1'b0) begin
                have = 1'b1;
                x    = mk_slot(K_PRINT, {13'b0, b}, 8'h00);
            end else if (b[7:5] == 3'b110) begin
                g.acc = {16'b0, b[4:0]};
                g.rem = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                g.acc = {17'b0, b[3:0]};
                g.rem = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                g.acc = {18'b0, b[2:0]};
                g.rem = 2'd3;
            end else begin
                have = 1'b1;
            end
            if (have) begin
                if (g.n == '0) begin
                    g.s0 = x;
                end else begin
                    g.s1 = x;
                end
                g.n = g.n + SLOT_W'(1);
            end
        end
        return g;
    endfunction

    t_parse_state      r_pstate, n_pstate;
    logic [1:0]        r_rem, n_rem;
    logic [20:0]       r_acc, n_acc;
    logic [15:0]       r_cur, n_cur;
    logic              r_seen, n_seen;
    logic [CW-1:0]     r_scnt, n_scnt;
    logic [SLOT_W-1:0] r_ev_n, n_ev_n;
    t_slot             r_slot [EV_SLOTS];
    t_slot             n_slot [EV_SLOTS];
    logic [7:0]        r_fin;
    logic              pre_disp;
    logic              wr_en;
    logic              room;
    logic [19:0]       prod;
    t_ground           g;

    logic [15:0]       r_mem [MAX_PARAMS];
    logic [15:0]       r_rd_data;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [20:0]       r_out_value;
    logic [7:0]        r_out_fin;
    logic [4:0]        r_out_idx;
    logic [5:0]        r_out_cnt;
    logic              r_out_last;
    t_slot             sel_slot;

    assign room = r_scnt < CW'(MAX_PARAMS);
    assign prod = ({4'b0, r_cur} << 3) + ({4'b0, r_cur} << 1) + {16'b0, i_data_byte[3:0]};
    assign g    = ground_eval(i_data_byte, r_rem, r_acc);

    always_comb begin
        n_pstate = r_pstate;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_cur    = r_cur;
        n_seen   = r_seen;
        n_scnt   = r_scnt;
        n_ev_n   = '0;
        pre_disp = 1'b0;
        wr_en    = 1'b0;
        for (int i = 0; i < EV_SLOTS; i++) begin
            n_slot[i] = '0;
        end
        case (r_pstate)
            P_ESC: begin
                n_pstate = P_GROUND;
                if (i_data_byte == B_CSI) begin
                    n_scnt   = '0;
                    n_cur    = '0;
                    n_seen   = 1'b0;
                    n_pstate = P_CSI;
                end else if (i_data_byte == B_OSC) begin
                    n_pstate = P_OSC;
                end else if (i_data_byte >= B_SP && i_data_byte < B_DEL) begin
                    n_ev_n    = SLOT_W'(1);
                    n_slot[0] = mk_slot(K_ESC_FINAL, {13'b0, i_data_byte}, 8'h00);
                end
            end
            P_CSI: begin
                if (i_data_byte >= B_DIG0 && i_data_byte <= B_DIG9) begin
                    if (prod > 20'(PARAM_LIMIT)) begin
                        n_cur = 16'(PARAM_LIMIT);
                    end else begin
                        n_cur = prod[15:0];
                    end
                    n_seen = 1'b1;
                end else if (i_data_byte == B_SEMI) begin
                    if (room) begin
                        wr_en  = 1'b1;
                        n_scnt = r_scnt + CW'(1);
                    end
                    n_cur  = '0;
                    n_seen = 1'b1;
                end else if (i_data_byte >= B_FIN_LO && i_data_byte <= B_FIN_HI) begin
                    if (r_seen && room) begin
                        wr_en  = 1'b1;
                        n_scnt = r_scnt + CW'(1);
                    end
                    if (r_scnt == '0 && !(r_seen && room)) begin
                        n_ev_n    = SLOT_W'(1);
                        n_slot[0] = mk_slot(K_CSI_PARAM, 21'd0, i_data_byte);
                    end else begin
                        pre_disp = 1'b1;
                    end
                    n_pstate = P_GROUND;
                end else if (i_data_byte == B_ESC) begin
                    n_pstate = P_ESC;
                end else if (i_data_byte >= B_SP && i_data_byte <= B_INT_HI) begin
                    n_pstate = P_CSI_IGN;
                end else if (i_data_byte < B_SP) begin
                    n_ev_n    = SLOT_W'(1);
                    n_slot[0] = mk_slot(K_EXECUTE, {13'b0, i_data_byte}, 8'h00);
                end
            end
            P_CSI_IGN: begin
                if (i_data_byte >= B_FIN_LO && i_data_byte <= B_FIN_HI) begin
                    n_pstate = P_GROUND;
                end else if (i_data_byte == B_ESC) begin
                    n_pstate = P_ESC;
                end
            end
            P_OSC: begin
                if (i_data_byte == B_BEL) begin
                    n_ev_n    = SLOT_W'(1);
                    n_slot[0] = mk_slot(K_OSC_END, 21'd0, 8'h00);
                    n_pstate  = P_GROUND;
                end else if (i_data_byte == B_ESC) begin
                    n_pstate = P_OSC_ESC;
                end else begin
                    n_ev_n    = SLOT_W'(1);
                    n_slot[0] = mk_slot(K_OSC_BYTE, {13'b0, i_data_byte}, 8'h00);
                end
            end
            P_OSC_ESC: begin
                n_ev_n    = SLOT_W'(1);
                n_slot[0] = mk_slot(K_OSC_END, 21'd0, 8'h00);
                n_pstate  = P_GROUND;
                if (i_data_byte != B_BSL) begin
                    n_ev_n    = SLOT_W'(1) + g.n;
                    n_slot[1] = g.s0;
                    n_slot[2] = g.s1;
                    n_rem     = g.rem;
                    n_acc     = g.acc;
                    if (g.esc) begin
                        n_pstate = P_ESC;
                    end
                end
            end
            default: begin
                n_ev_n    = g.n;
                n_slot[0] = g.s0;
                n_slot[1] = g.s1;
                n_rem     = g.rem;
                n_acc     = g.acc;
                n_pstate  = g.esc ? P_ESC : P_GROUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate <= P_GROUND;
            r_rem    <= '0;
            r_acc    <= '0;
            r_cur    <= '0;
            r_seen   <= 1'b0;
            r_scnt   <= '0;
            r_ev_n   <= '0;
        end else if (i_cmd.take) begin
            r_pstate <= n_pstate;
            r_rem    <= n_rem;
            r_acc    <= n_acc;
            r_cur    <= n_cur;
            r_seen   <= n_seen;
            r_scnt   <= n_scnt;
            r_ev_n   <= n_ev_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_slot <= n_slot;
            r_fin  <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && wr_en) begin
            r_mem[r_scnt[IW-1:0]] <= r_cur;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign sel_slot = r_slot[i_cmd.slot_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_evt || i_cmd.load_par) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_evt) begin
            r_out_kind  <= sel_slot.kind;
            r_out_value <= sel_slot.value;
            r_out_fin   <= sel_slot.csi_final;
            r_out_idx   <= '0;
            r_out_cnt   <= '0;
            r_out_last  <= i_cmd.last;
        end else if (i_cmd.load_par) begin
            r_out_kind  <= K_CSI_PARAM;
            r_out_value <= {5'b0, r_rd_data};
            r_out_fin   <= r_fin;
            r_out_idx   <= 5'(i_par_idx);
            r_out_cnt   <= 6'(r_scnt);
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_status.pre_disp = pre_disp;
    assign o_status.pre_n    = n_ev_n;
    assign o_status.ev_n     = r_ev_n;
    assign o_status.out_free = !r_out_valid || o_event.ready;
    assign o_disp_cnt        = r_scnt;

    assign o_event.valid       = r_out_valid;
    assign o_event.event_kind  = r_out_kind;
    assign o_event.event_value = r_out_value;
    assign o_event.csi_final   = r_out_fin;
    assign o_event.param_index = r_out_idx;
    assign o_event.param_count = r_out_cnt;
    assign o_event.last        = r_out_last;

endmodule

### design/vt_escape_utf8_parser.sv
// ----------------------------------------------------------------------------
// vt_escape_utf8_parser: terminal escape sequence parser with UTF-8 decoding
// Turns a raw terminal byte stream into print, execute, escape, CSI and OSC
// events.
// ----------------------------------------------------------------------------
// Bytes arrive on i_byte and events leave on o_event; each transfer happens
// when valid and ready are both high, and the last event caused by a byte
// carries last set.
// The sequencer loads the events of a taken byte from slot registers into
// the output register in order. Bytes that cause no event or a single
// event stream at one per cycle while the receiver does not stall; a byte
// that causes k events, at most three outside a CSI final, sends them in turn.
// A CSI final with n stored parameters is handled in steps: decode of the
// byte, the first parameter memory read, and then one parameter per cycle
// from the single read port of that memory while the receiver does not stall.
// When the receiver stalls, the output register holds its event and the
// sequencer waits; no byte is taken while events of the previous one remain.
// Synchronous reset returns the parser to the ground state with no pending
// UTF-8 sequence, no stored parameters and an empty output register.
// ----------------------------------------------------------------------------
module vt_escape_utf8_parser
    import vep_pkg::*;
#(
    parameter int MAX_PARAMS  = DEFAULT_MAX_PARAMS,
    parameter int PARAM_LIMIT = DEFAULT_PARAM_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vep_byte_if.sink    i_byte,
    vep_event_if.source o_event
);

    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);

    t_cmd          w_cmd;
    t_status       w_status;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_par_idx;
    logic [CW-1:0] w_disp_cnt;
    logic          w_in_ready;

    assign i_byte.ready = w_in_ready;

    vep_ctrl #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .i_disp_cnt (w_disp_cnt),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_par_idx  (w_par_idx)
    );

    vep_datapath #(
        .MAX_PARAMS  (MAX_PARAMS),
        .PARAM_LIMIT (PARAM_LIMIT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_byte.data_byte),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .i_par_idx   (w_par_idx),
        .o_status    (w_status),
        .o_disp_cnt  (w_disp_cnt),
        .o_event     (o_event)
    );

endmodule

### design/vep_checker.sv
// ----------------------------------------------------------------------------
// vep_checker: port level assertions of the parser
// Checks the event channel of the top level over time and is bound to it.
// ----------------------------------------------------------------------------
module vep_checker
    import vep_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [20:0] i_value,
    input logic [7:0]  i_fin,
    input logic [4:0]  i_idx,
    input logic [5:0]  i_cnt,
    input logic        i_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Event output valid after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_kind, i_value, i_fin, i_idx, i_cnt, i_last}))
        else $error("Stalled event changed before its transfer.");

    a_side_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != K_CSI_PARAM |-> i_fin == 8'd0 && i_idx == 5'd0 &&
            i_cnt == 6'd0)
        else $error("Non-CSI event carries CSI fields.");

    a_exec_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_EXECUTE |->
            i_value < 21'(B_SP) || i_value == 21'(B_DEL))
        else $error("Execute event with a printable byte.");

    a_param_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_CSI_PARAM && i_cnt != 6'd0 |-> {1'b0, i_idx} < i_cnt)
        else $error("CSI parameter index beyond its count.");

endmodule

bind vt_escape_utf8_parser vep_checker u_vep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_event.valid),
    .i_out_ready (o_event.ready),
    .i_kind      (o_event.event_kind),
    .i_value     (o_event.event_value),
    .i_fin       (o_event.csi_final),
    .i_idx       (o_event.param_index),
    .i_cnt       (o_event.param_count),
    .i_last      (o_event.last)
);
